// ===== rtl/yfrc_pkg.sv =====
// Shared constants, register indexes and types of the yaw follow rate controller.
package yfrc_pkg;

	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = 2;

	localparam logic [CfgIdxW-1:0] REG_ANGLE_DEADBAND = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KNEE_ANGLE     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GAIN_SMALL     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAIN_LARGE     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FF_GAIN        = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RATE_LIMIT     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT     = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_RATE_DEADBAND  = 3'd7;

	localparam logic signed [16:0] FF_SAT = 17'sd65535;

	typedef struct packed {
		logic [11:0] angle_deadband;
		logic [15:0] knee_angle;
		logic [13:0] gain_small;
		logic [13:0] gain_large;
		logic [10:0] ff_gain;
		logic [15:0] rate_limit;
		logic [15:0] step_limit;
		logic [14:0] rate_deadband;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] feedback_part;
		logic signed [16:0] feedforward_part;
	} part_t;

endpackage

// ===== rtl/yfrc_in_if.sv =====
// Input channel: heading offset and lead rate with valid/ready.
interface yfrc_in_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] heading_offset;
	logic signed [19:0] lead_rate;

	modport source(output valid, heading_offset, lead_rate, input ready);
	modport sink(input valid, heading_offset, lead_rate, output ready);
endinterface

// ===== rtl/yfrc_out_if.sv =====
// Output channel: rate target, feedback and feedforward parts with valid/ready.
interface yfrc_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] rate_target;
	logic signed [16:0] feedback_part;
	logic signed [16:0] feedforward_part;

	modport source(output valid, rate_target, feedback_part, feedforward_part, input ready);
	modport sink(input valid, rate_target, feedback_part, feedforward_part, output ready);
endinterface

// ===== rtl/yfrc_front.sv =====
// Front end: deadbands, two-slope gain, feedforward gain and saturation, two stages.
module yfrc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  yfrc_pkg::cfg_t cfg,
	yfrc_in_if.sink        in_ch,
	output logic           q_valid,
	output yfrc_pkg::part_t q_data,
	input  logic           q_ready
);
	import yfrc_pkg::*;

	logic               ready_s1, ready_s2;
	logic               valid_s1, valid_s2;

	logic signed [17:0] off_x, adb, e;
	logic        [17:0] e_abs;
	logic        [16:0] mag, knee_x, mul_a, diff;
	logic               above, neg;
	logic signed [20:0] lead_x, rdb, ffd;

	logic               neg_s1;
	logic        [16:0] mul_a_s1, diff_s1;
	logic signed [19:0] ffd_s1;

	logic               neg_s2;
	logic        [30:0] p_small_s2, p_large_s2;
	logic signed [31:0] p_ff_s2;

	logic        [23:0] mag_sum;
	logic        [15:0] mag_c;
	logic signed [23:0] ff_sh;

	assign ready_s2    = !valid_s2 || q_ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign in_ch.ready = ready_s1;

	always_comb begin
		off_x = {in_ch.heading_offset[16], in_ch.heading_offset};
		adb   = $signed({6'b0, cfg.angle_deadband});
		if (off_x > adb) begin
			e = off_x - adb;
		end else if (off_x < -adb) begin
			e = off_x + adb;
		end else begin
			e = '0;
		end
		e_abs  = e[17] ? 18'(-e) : 18'(e);
		mag    = e_abs[16:0];
		neg    = !e[17] && (e != '0);
		knee_x = {1'b0, cfg.knee_angle};
		above  = mag > knee_x;
		mul_a  = above ? knee_x : mag;
		diff   = above ? 17'(mag - knee_x) : '0;

		lead_x = {in_ch.lead_rate[19], in_ch.lead_rate};
		rdb    = $signed({6'b0, cfg.rate_deadband});
		if (lead_x > rdb) begin
			ffd = lead_x - rdb;
		end else if (lead_x < -rdb) begin
			ffd = lead_x + rdb;
		end else begin
			ffd = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && ready_s1) begin
			neg_s1   <= neg;
			mul_a_s1 <= mul_a;
			diff_s1  <= diff;
			ffd_s1   <= ffd[19:0];
		end
		if (valid_s1 && ready_s2) begin
			neg_s2     <= neg_s1;
			p_small_s2 <= 31'(cfg.gain_small) * 31'(mul_a_s1);
			p_large_s2 <= 31'(cfg.gain_large) * 31'(diff_s1);
			p_ff_s2    <= 32'(ffd_s1) * $signed(32'({1'b0, cfg.ff_gain}));
		end
	end

	always_comb begin
		mag_sum = 24'(p_small_s2[30:8]) + 24'(p_large_s2[30:8]);
		mag_c   = (mag_sum > 24'(cfg.rate_limit)) ? cfg.rate_limit : mag_sum[15:0];
		q_data.feedback_part = neg_s2 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

		ff_sh = p_ff_s2[31:8];
		if (ff_sh > 24'(FF_SAT)) begin
			q_data.feedforward_part = FF_SAT;
		end else if (ff_sh < -24'(FF_SAT)) begin
			q_data.feedforward_part = -FF_SAT;
		end else begin
			q_data.feedforward_part = ff_sh[16:0];
		end
	end

	assign q_valid = valid_s2;

endmodule

// ===== rtl/yfrc_fifo.sv =====
// Short queue between front and back end.
module yfrc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  yfrc_pkg::part_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output yfrc_pkg::part_t pop_data
);
	import yfrc_pkg::*;

	part_t               mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FifoPtrW:0]   count_q;
	logic                push, pop;

	assign push_ready = count_q != (FifoPtrW+1)'(FifoDepth);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/yfrc_back.sv =====
// Back end: sum clamp, slew limit against the stored target, output register.
module yfrc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  yfrc_pkg::cfg_t  cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  yfrc_pkg::part_t pop_data,
	yfrc_out_if.source      out_ch
);
	import yfrc_pkg::*;

	logic signed [16:0] last_target_q;
	logic               out_valid_q;
	logic signed [16:0] rate_target_q, feedback_q, feedforward_q;

	logic signed [17:0] sum, lim, sum_c, dlt, stp, tgt;
	logic               take;

	assign pop_ready = !out_valid_q || out_ch.ready;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		sum = 18'(pop_data.feedback_part) + 18'(pop_data.feedforward_part);
		lim = $signed({2'b0, cfg.rate_limit});
		if (sum > lim) begin
			sum_c = lim;
		end else if (sum < -lim) begin
			sum_c = -lim;
		end else begin
			sum_c = sum;
		end
		dlt = sum_c - 18'(last_target_q);
		stp = $signed({2'b0, cfg.step_limit});
		if (dlt > stp) begin
			tgt = 18'(last_target_q) + stp;
		end else if (dlt < -stp) begin
			tgt = 18'(last_target_q) - stp;
		end else begin
			tgt = sum_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			last_target_q <= '0;
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (take) begin
				last_target_q <= tgt[16:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rate_target_q <= tgt[16:0];
			feedback_q    <= pop_data.feedback_part;
			feedforward_q <= pop_data.feedforward_part;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.rate_target      = rate_target_q;
	assign out_ch.feedback_part    = feedback_q;
	assign out_ch.feedforward_part = feedforward_q;

endmodule

// ===== rtl/yaw_follow_rate_controller_core.sv =====
// Top level: configuration registers, front end, queue and back end.
// From input transfer to result valid, an item passes the two front stages, the queue and the output register.
// Throughput: one item per cycle while the output accepts results, set by the two-stage front and the back end.
// The queue holds up to 4 classified items while the output stalls.
// Reset clears all valid state and the stored target to 0, registers to their defaults.
module yaw_follow_rate_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [yfrc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [yfrc_pkg::CfgDataW-1:0] cfg_data,
	yfrc_in_if.sink                       in_ch,
	yfrc_out_if.source                    out_ch
);
	import yfrc_pkg::*;

	cfg_t  cfg_q;
	logic  fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;
	part_t fq_in_data, fq_out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_deadband <= 12'd128;
			cfg_q.knee_angle     <= 16'd1024;
			cfg_q.gain_small     <= 14'd3840;
			cfg_q.gain_large     <= 14'd1792;
			cfg_q.ff_gain        <= 11'd0;
			cfg_q.rate_limit     <= 16'd30720;
			cfg_q.step_limit     <= 16'd768;
			cfg_q.rate_deadband  <= 15'd205;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANGLE_DEADBAND: cfg_q.angle_deadband <= cfg_data[11:0];
				REG_KNEE_ANGLE:     cfg_q.knee_angle     <= cfg_data;
				REG_GAIN_SMALL:     cfg_q.gain_small     <= cfg_data[13:0];
				REG_GAIN_LARGE:     cfg_q.gain_large     <= cfg_data[13:0];
				REG_FF_GAIN:        cfg_q.ff_gain        <= cfg_data[10:0];
				REG_RATE_LIMIT:     cfg_q.rate_limit     <= cfg_data;
				REG_STEP_LIMIT:     cfg_q.step_limit     <= cfg_data;
				REG_RATE_DEADBAND:  cfg_q.rate_deadband  <= cfg_data[14:0];
			endcase
		end
	end

	yfrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.q_valid (fq_in_valid),
		.q_data  (fq_in_data),
		.q_ready (fq_in_ready)
	);

	yfrc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_in_valid),
		.push_ready (fq_in_ready),
		.push_data  (fq_in_data),
		.pop_valid  (fq_out_valid),
		.pop_ready  (fq_out_ready),
		.pop_data   (fq_out_data)
	);

	yfrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (fq_out_valid),
		.pop_ready (fq_out_ready),
		.pop_data  (fq_out_data),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	a_fb_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.feedback_part <= $signed({1'b0, cfg_q.rate_limit}))
			&& (out_ch.feedback_part >= -$signed({1'b0, cfg_q.rate_limit})))
		else $error("feedback part exceeds rate limit");

	a_ff_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.feedforward_part != -17'sd65536))
		else $error("feedforward part below saturation bound");

	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fq_in_valid && !fq_in_ready) |=> (fq_in_valid && $stable(fq_in_data)))
		else $error("front end dropped a stalled transfer");
`endif

endmodule

// ===== test/yfrc_rate_checker.sv =====
// Checker for the yaw follow rate controller: predicts each rate command and compares it.
module yfrc_rate_checker
	import yfrc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	yfrc_in_if                  in_mon,
	yfrc_out_if                 out_mon,
	output int                  fails,
	output int                  pending
);

	typedef struct packed {
		logic signed [16:0] rate_target;
		logic signed [16:0] feedback_part;
		logic signed [16:0] feedforward_part;
	} rate_cmd_t;

	localparam cfg_t CfgReset = '{
		angle_deadband: 12'd128,
		knee_angle:     16'd1024,
		gain_small:     14'd3840,
		gain_large:     14'd1792,
		ff_gain:        11'd0,
		rate_limit:     16'd30720,
		step_limit:     16'd768,
		rate_deadband:  15'd205
	};

	cfg_t               cfg;
	logic signed [16:0] last_target;
	rate_cmd_t          expected_cmds[$];

	function automatic longint shrink_by_deadband(longint v, longint d);
		if (v > d)
			return v - d;
		if (v < -d)
			return v + d;
		return 0;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic rate_cmd_t predict_rate_cmd(cfg_t c, logic signed [16:0] prev,
			logic signed [16:0] offset, logic signed [19:0] lead);
		longint    err, mag, fb, ff, sum, knee, lim, stp, base, tgt;
		rate_cmd_t cmd;
		knee = longint'(c.knee_angle);
		lim  = longint'(c.rate_limit);
		stp  = longint'(c.step_limit);
		base = longint'(prev);
		err  = shrink_by_deadband(longint'(offset), longint'(c.angle_deadband));
		mag  = (err < 0) ? -err : err;
		if (mag <= knee) begin
			mag = longint'(c.gain_small) * mag / 256;
		end else begin
			mag = longint'(c.gain_small) * knee / 256
				+ longint'(c.gain_large) * (mag - knee) / 256;
		end
		if (mag > lim)
			mag = lim;
		fb  = (err > 0) ? -mag : mag;
		ff  = shrink_by_deadband(longint'(lead), longint'(c.rate_deadband))
			* longint'(c.ff_gain);
		ff  = clamp_mag(ff >>> 8, longint'(FF_SAT));
		sum = clamp_mag(fb + ff, lim);
		if (sum - base > stp)
			tgt = base + stp;
		else if (sum - base < -stp)
			tgt = base - stp;
		else
			tgt = sum;
		cmd.rate_target      = 17'(tgt);
		cmd.feedback_part    = 17'(fb);
		cmd.feedforward_part = 17'(ff);
		return cmd;
	endfunction

	task automatic check_field(input string name, input logic signed [16:0] want,
			input logic signed [16:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	initial begin
		rate_cmd_t cmd;
		rate_cmd_t want;
		fails       = 0;
		pending     = 0;
		cfg         = CfgReset;
		last_target = '0;
		forever begin
			@(posedge clk or negedge arst_n);
			if (!arst_n) begin
				cfg         = CfgReset;
				last_target = '0;
				expected_cmds.delete();
			end else begin
				if (cfg_we) begin
					case (cfg_index)
						REG_ANGLE_DEADBAND: cfg.angle_deadband = cfg_data[11:0];
						REG_KNEE_ANGLE:     cfg.knee_angle     = cfg_data[15:0];
						REG_GAIN_SMALL:     cfg.gain_small     = cfg_data[13:0];
						REG_GAIN_LARGE:     cfg.gain_large     = cfg_data[13:0];
						REG_FF_GAIN:        cfg.ff_gain        = cfg_data[10:0];
						REG_RATE_LIMIT:     cfg.rate_limit     = cfg_data[15:0];
						REG_STEP_LIMIT:     cfg.step_limit     = cfg_data[15:0];
						REG_RATE_DEADBAND:  cfg.rate_deadband  = cfg_data[14:0];
					endcase
				end
				if (in_mon.valid && in_mon.ready) begin
					cmd = predict_rate_cmd(cfg, last_target, in_mon.heading_offset,
						in_mon.lead_rate);
					last_target = cmd.rate_target;
					expected_cmds.push_back(cmd);
				end
				if (out_mon.valid && out_mon.ready) begin
					if (expected_cmds.size() == 0) begin
						fails++;
						$display("%0t: unexpected transfer, expected none, actual %0d %0d %0d",
							$time, out_mon.rate_target, out_mon.feedback_part,
							out_mon.feedforward_part);
					end else begin
						want = expected_cmds.pop_front();
						check_field("rate_target", want.rate_target, out_mon.rate_target);
						check_field("feedback_part", want.feedback_part, out_mon.feedback_part);
						check_field("feedforward_part", want.feedforward_part,
							out_mon.feedforward_part);
					end
				end
			end
			pending = expected_cmds.size();
		end
	end

endmodule

// ===== test/tb_yaw_follow_rate_controller_core.sv =====
// Testbench top for the yaw follow rate controller: clock, reset, stimulus and verdict.
module tb_yaw_follow_rate_controller_core;
	import yfrc_pkg::*;

	localparam int WatchLimit = 5000;
	localparam int Phases     = 12;
	localparam int PhaseItems = 156;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	int                  fails;
	int                  pending;
	int                  sent;
	logic                calm;
	cfg_t                cur_cfg;

	yfrc_in_if  in_ch();
	yfrc_out_if out_ch();

	yaw_follow_rate_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	yfrc_rate_checker rate_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.fails     (fails),
		.pending   (pending)
	);

	assign calm = (sent >= 900) && (sent < 1100);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_cmd(input logic signed [16:0] off, input logic signed [19:0] lead);
		while (!calm && $urandom_range(99) < 14) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.heading_offset <= off;
		in_ch.lead_rate      <= lead;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataW'(val);
		@(posedge clk);
	endtask

	task automatic load_cfg(input cfg_t c);
		put_reg(REG_ANGLE_DEADBAND, c.angle_deadband);
		put_reg(REG_KNEE_ANGLE, c.knee_angle);
		put_reg(REG_GAIN_SMALL, c.gain_small);
		put_reg(REG_GAIN_LARGE, c.gain_large);
		put_reg(REG_FF_GAIN, c.ff_gain);
		put_reg(REG_RATE_LIMIT, c.rate_limit);
		put_reg(REG_STEP_LIMIT, c.step_limit);
		put_reg(REG_RATE_DEADBAND, c.rate_deadband);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic int unsigned pick_reg(int unsigned full_max, int unsigned hi,
			int unsigned dflt);
		case ($urandom_range(9))
			0:       return 0;
			1:       return full_max;
			2:       return hi;
			3:       return dflt;
			default: return $urandom_range(hi);
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.angle_deadband = 12'(pick_reg(4095, 2560, 128));
		c.knee_angle     = 16'(pick_reg(65535, 46080, 1024));
		c.gain_small     = 14'(pick_reg(16383, 16383, 3840));
		c.gain_large     = 14'(pick_reg(16383, 16383, 1792));
		c.ff_gain        = 11'(pick_reg(2047, 1024, 256));
		c.rate_limit     = 16'(pick_reg(65535, 65535, 30720));
		c.step_limit     = 16'(pick_reg(65535, 65535, 768));
		c.rate_deadband  = 15'(pick_reg(32767, 25600, 205));
		return c;
	endfunction

	initial begin
		int                 walk;
		int                 near;
		logic signed [16:0] off;
		logic signed [19:0] lead;
		sent                 = 0;
		walk                 = 0;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		in_ch.valid          <= 1'b0;
		in_ch.heading_offset <= '0;
		in_ch.lead_rate      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// deadband edges, knee edge, range and full-width extremes at reset settings
		send_cmd(17'sd0, 20'sd0);
		send_cmd(17'sd128, 20'sd0);
		send_cmd(17'sd129, 20'sd0);
		send_cmd(-17'sd129, 20'sd0);
		send_cmd(17'sd1152, 20'sd0);
		send_cmd(17'sd1153, 20'sd0);
		send_cmd(17'sd46080, 20'sd0);
		send_cmd(-17'sd46080, 20'sd0);
		send_cmd(17'h10000, 20'sd0);
		send_cmd(17'sd65535, 20'sd0);

		// feedforward deadband edges and saturation
		drain();
		load_cfg(cfg_t'{12'd128, 16'd1024, 14'd3840, 14'd1792, 11'd1024, 16'd65535,
			16'd65535, 15'd205});
		send_cmd(17'sd0, 20'sd205);
		send_cmd(17'sd0, 20'sd206);
		send_cmd(17'sd0, -20'sd206);
		send_cmd(17'sd0, 20'sd512000);
		send_cmd(17'sd0, -20'sd512000);
		send_cmd(17'sd0, 20'h80000);
		send_cmd(17'sd0, 20'sd524287);
		send_cmd(-17'sd20000, 20'sd300000);

		drain();
		load_cfg(cfg_t'{12'd4095, 16'd65535, 14'd16383, 14'd16383, 11'd2047, 16'd65535,
			16'd65535, 15'd32767});
		send_cmd(17'sd46080, -20'sd512000);
		send_cmd(17'h10000, 20'sd524287);

		drain();
		load_cfg('0);
		send_cmd(17'sd1000, -20'sd1000);
		send_cmd(-17'sd1, 20'sd1);

		for (int ph = 0; ph < Phases; ph++) begin
			drain();
			load_cfg(random_cfg());
			for (int n = 0; n < PhaseItems; n++) begin
				case ($urandom_range(9))
					0: off = 17'($urandom);
					1, 2: begin
						near = int'(cur_cfg.angle_deadband) + int'($urandom_range(6)) - 3;
						if ($urandom_range(1))
							near += int'(cur_cfg.knee_angle);
						off = 17'($urandom_range(1) ? -near : near);
					end
					3, 4, 5: begin
						walk += int'($urandom_range(2000)) - 1000;
						if (walk > 46080)
							walk = 46080;
						if (walk < -46080)
							walk = -46080;
						off = 17'(walk);
					end
					default: off = 17'(int'($urandom_range(92160)) - 46080);
				endcase
				case ($urandom_range(9))
					0: lead = 20'($urandom);
					1, 2: begin
						near = int'(cur_cfg.rate_deadband) + int'($urandom_range(6)) - 3;
						lead = 20'($urandom_range(1) ? -near : near);
					end
					default: lead = 20'(int'($urandom_range(1024000)) - 512000);
				endcase
				send_cmd(off, lead);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("yaw_follow_rate_controller_core regression: pass");
		else
			$display("yaw_follow_rate_controller_core regression: fail");
		$finish;
	end

	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent >= 400) begin
				held = 1'b1;
				hold = 200;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 14);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchLimit) begin
				$display("yaw_follow_rate_controller_core regression: fail");
				$finish;
			end
		end
	end

endmodule
